// ----- hdl/b64d_pkg.sv -----
`default_nettype none

package b64d_pkg;

  localparam int SYM_W    = 8;
  localparam int VAL_W    = 6;
  localparam int GROUP_W  = 3 * VAL_W;
  localparam int MAX_ITEMS = 3;

  localparam logic FUNC_CHAR   = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
  localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
  localparam logic [5:0] VAL_DASH       = 6'd62;
  localparam logic [5:0] VAL_UNDER      = 6'd63;

  // trailing bits that must be zero in a two- or three-symbol tail
  localparam logic [GROUP_W-1:0] TAIL2_MASK = GROUP_W'(8'h0F);
  localparam logic [GROUP_W-1:0] TAIL3_MASK = GROUP_W'(8'h03);

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TAIL_ONE  = 2'd1,
    ERR_ILLEGAL   = 2'd2,
    ERR_TAIL_BITS = 2'd3
  } err_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] val;
  } sym_val_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    err_t       status;
    logic       last;
  } out_item_t;

  // up to three result items caused by one input item
  typedef struct packed {
    logic [1:0]                  n_items;
    out_item_t [MAX_ITEMS-1:0]   items;
  } job_t;

  function automatic sym_val_t sym_to_val(input logic [SYM_W-1:0] ch);
    sym_val_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      r.val = 6'(ch - CH_UPPER_A);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      r.val = 6'(ch - CH_LOWER_A) + VAL_LOWER_BASE;
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      r.val = 6'(ch - CH_DIGIT_0) + VAL_DIGIT_BASE;
    end else if (ch == CH_DASH) begin
      r.val = VAL_DASH;
    end else if (ch == CH_UNDER) begin
      r.val = VAL_UNDER;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic out_item_t data_item(input logic [7:0] b);
    out_item_t it;
    it.kind      = KIND_DATA;
    it.data_byte = b;
    it.status    = ERR_NONE;
    it.last      = 1'b0;
    return it;
  endfunction

  function automatic out_item_t status_item(input err_t e);
    out_item_t it;
    it.kind      = KIND_STATUS;
    it.data_byte = 8'h00;
    it.status    = e;
    it.last      = 1'b1;
    return it;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/b64d_if.sv -----
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output kind, output data_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/b64d_front.sv -----
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  b64d_in_if.sink     in_ch,
  input  wire logic   q_full,
  output logic        push,
  output job_t        push_job
);

  logic [GROUP_W-1:0] group_r, group_nxt;
  logic [1:0]         count_r, count_nxt;
  err_t               err_r, err_nxt;

  logic               accept;
  sym_val_t           sv;
  logic [23:0]        triple;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sv          = sym_to_val(in_ch.symbol);
  assign triple      = {group_r, sv.val};

  always_comb begin
    group_nxt = group_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    push      = 1'b0;
    push_job  = '0;

    if (accept) begin
      if (in_ch.func == FUNC_CHAR) begin
        if (err_r == ERR_NONE) begin
          if (!sv.ok) begin
            err_nxt   = ERR_ILLEGAL;
            group_nxt = '0;
            count_nxt = '0;
          end else if (count_r != 2'd3) begin
            group_nxt = {group_r[GROUP_W-VAL_W-1:0], sv.val};
            count_nxt = count_r + 2'd1;
          end else begin
            push              = 1'b1;
            push_job.n_items  = 2'd3;
            push_job.items[0] = data_item(triple[23:16]);
            push_job.items[1] = data_item(triple[15:8]);
            push_job.items[2] = data_item(triple[7:0]);
            group_nxt         = '0;
            count_nxt         = '0;
          end
        end
      end else begin
        // finish: optional tail bytes, then the closing status
        push              = 1'b1;
        push_job.n_items  = 2'd1;
        push_job.items[0] = status_item(err_r);
        if (err_r == ERR_NONE) begin
          case (count_r)
            2'd1: push_job.items[0] = status_item(ERR_TAIL_ONE);
            2'd2: begin
              if ((group_r & TAIL2_MASK) != '0) begin
                push_job.items[0] = status_item(ERR_TAIL_BITS);
              end else begin
                push_job.n_items  = 2'd2;
                push_job.items[0] = data_item(group_r[11:4]);
                push_job.items[1] = status_item(ERR_NONE);
              end
            end
            2'd3: begin
              if ((group_r & TAIL3_MASK) != '0) begin
                push_job.items[0] = status_item(ERR_TAIL_BITS);
              end else begin
                push_job.n_items  = 2'd3;
                push_job.items[0] = data_item(group_r[17:10]);
                push_job.items[1] = data_item(group_r[9:2]);
                push_job.items[2] = status_item(ERR_NONE);
              end
            end
            default: ;
          endcase
        end
        group_nxt = '0;
        count_nxt = '0;
        err_nxt   = ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
      count_r <= '0;
      err_r   <= ERR_NONE;
    end else begin
      group_r <= group_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/b64d_queue.sv -----
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  job_t       push_job,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output job_t       head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/b64d_back.sv -----
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  job_t       head_job,
  output logic       pop,
  b64d_out_if.source out_ch
);

  logic       out_valid_r;
  out_item_t  out_item_r;
  logic [1:0] idx_r;
  logic       load;
  logic       last_of_job;

  assign load        = !out_valid_r || out_ch.ready;
  assign last_of_job = (idx_r == head_job.n_items - 2'd1);
  assign pop         = load && head_valid && last_of_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        idx_r <= last_of_job ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_item_r <= head_job.items[idx_r];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_item_r.kind;
  assign out_ch.data_byte = out_item_r.data_byte;
  assign out_ch.status    = out_item_r.status;
  assign out_ch.last      = out_item_r.last;

endmodule

`default_nettype wire

// ----- hdl/strict_base64url_decoder_unit.sv -----
// Path: a result item passes through the job queue and then the output register.
// Throughput: one character per cycle unless the job queue is full; the output
//   register drains one item per cycle unless out_ch stalls, so a group's three
//   bytes or a finish's up to three items leave as the queue takes characters.
// Reset (rst_n low, synchronous): group, count and error cleared, queue empty.
`default_nettype none

module strict_base64url_decoder_unit
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  b64d_in_if.sink    in_ch,
  b64d_out_if.source out_ch
);

  logic push, pop, q_full, head_valid;
  job_t push_job, head_job;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job popped from empty queue");

  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_STATUS) |-> out_ch.last)
    else $error("status item without last");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_DATA) |->
      (!out_ch.last && out_ch.status == ERR_NONE))
    else $error("data item carries status or last");

endmodule

`default_nettype wire
